/* hw/rtl/swm2_pkg.sv */
// package for the two-dimensional sliding window minimum filter
// holds item types, register codes, field widths and the signed minimum
// depends on nothing
`timescale 1ns / 1ps

package swm2_pkg;

    localparam int DATA_W        = 32;
    localparam int POS_OUT_W     = 10;
    localparam int MATRIX_SIDE_W = 11;
    localparam int WINDOW_SIDE_W = 5;
    localparam int CFG_DATA_W    = 11;

    localparam logic [MATRIX_SIDE_W-1:0] MATRIX_SIDE_RST = 11'd1024;
    localparam logic [WINDOW_SIDE_W-1:0] WINDOW_SIDE_RST = 5'd1;

    typedef enum logic [0:0] {
        REG_MATRIX_SIDE = 1'b0,
        REG_WINDOW_SIDE = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pixel_value;
        logic                     frame_start;
    } pixel_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] window_min;
        logic [POS_OUT_W-1:0]     out_row;
        logic [POS_OUT_W-1:0]     out_col;
        logic                     last;
    } result_item_t;

    // controls shared by every line buffer cell
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic fwd_hit;
    } line_ctrl_t;

    function automatic logic signed [DATA_W-1:0] smin(
        input logic signed [DATA_W-1:0] a,
        input logic signed [DATA_W-1:0] b
    );
        return (a <= b) ? a : b;
    endfunction

endpackage

/* hw/rtl/swm2_hcell.sv */
// horizontal cell: running minimum over the last few values of a row
// cell k holds the minimum of the newest k+1 values; uses swm2_pkg
`timescale 1ns / 1ps

module swm2_hcell (
    input  logic                                clk,
    input  logic                                shift_en,
    input  logic signed [swm2_pkg::DATA_W-1:0]  pixel,
    input  logic signed [swm2_pkg::DATA_W-1:0]  prev_min,
    output logic signed [swm2_pkg::DATA_W-1:0]  run_min
);

    logic signed [swm2_pkg::DATA_W-1:0] run_min_reg;
    logic signed [swm2_pkg::DATA_W-1:0] run_min_next;

    assign run_min_next = swm2_pkg::smin(pixel, prev_min);

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            run_min_reg <= run_min_next;
        end
    end

    assign run_min = run_min_reg;

endmodule

/* hw/rtl/swm2_vcell.sv */
// vertical cell: one line of column minima over the most recent rows
// line j holds per column the minimum over j+1 row minima; uses swm2_pkg
`timescale 1ns / 1ps

module swm2_vcell #(
    parameter  int DEPTH  = 1024,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                                clk,
    input  swm2_pkg::line_ctrl_t                ctrl,
    input  logic [ADDR_W-1:0]                   rd_addr,
    input  logic [ADDR_W-1:0]                   wr_addr,
    input  logic signed [swm2_pkg::DATA_W-1:0]  row_min,
    input  logic signed [swm2_pkg::DATA_W-1:0]  prev_old,
    output logic signed [swm2_pkg::DATA_W-1:0]  old_val
);

    logic signed [swm2_pkg::DATA_W-1:0] line_mem [DEPTH];
    logic signed [swm2_pkg::DATA_W-1:0] rd_reg;
    logic signed [swm2_pkg::DATA_W-1:0] fwd_reg;
    logic signed [swm2_pkg::DATA_W-1:0] new_val;

    assign new_val = swm2_pkg::smin(row_min, prev_old);

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            line_mem[wr_addr] <= new_val;
        end
        if (ctrl.rd_en)
        begin
            rd_reg  <= line_mem[rd_addr];
            fwd_reg <= new_val;
        end
    end

    // read raced the write of the item just ahead
    assign old_val = ctrl.fwd_hit ? fwd_reg : rd_reg;

endmodule

/* hw/rtl/sliding_window_min_2d.sv */
// top level of the two-dimensional sliding window minimum filter
// chains of horizontal and vertical min cells; uses swm2_pkg, swm2_hcell, swm2_vcell
`timescale 1ns / 1ps

//  channel   direction  handshake                   payload
//  pixel     in         pixel_valid / pixel_stall   pixel_item  (pixel_item_t)
//  result    out        result_valid / result_stall result_item (result_item_t)
//  cfg       in         cfg_we                      cfg_index, cfg_data
//
//  one item per clock sustained while pixel_stall is low; an item passes the stage one and output registers
//  the rate is set by one read and one write per line memory per item
//  reset clears positions, pipeline valids and config (side 1024, window 1)
//  line memories are not cleared; no clearing pass, no startup delay
//  result_stall holds the output register; the pixel side stalls only when
//  that register is full and the stage behind it holds a result too

module sliding_window_min_2d #(
    parameter int MAX_SIDE   = 1024,
    parameter int MAX_WINDOW = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   pixel_valid,
    output logic                                   pixel_stall,
    input  swm2_pkg::pixel_item_t                  pixel_item,
    output logic                                   result_valid,
    input  logic                                   result_stall,
    output swm2_pkg::result_item_t                 result_item,
    input  logic                                   cfg_we,
    input  swm2_pkg::cfg_reg_t                     cfg_index,
    input  logic [swm2_pkg::CFG_DATA_W-1:0]        cfg_data
);

    localparam int POS_W  = $clog2(MAX_SIDE);
    localparam int SIDE_W = $clog2(MAX_SIDE + 1);
    localparam int CW     = ((SIDE_W > swm2_pkg::WINDOW_SIDE_W) ?
                             SIDE_W : swm2_pkg::WINDOW_SIDE_W) + 1;
    localparam int TAPS   = (MAX_WINDOW > 1) ? MAX_WINDOW - 1 : 1;
    localparam int TAP_W  = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int OUT_W  = swm2_pkg::POS_OUT_W;
    localparam int WS_W   = swm2_pkg::WINDOW_SIDE_W;

    // configuration
    logic [swm2_pkg::MATRIX_SIDE_W-1:0] matrix_side_reg;
    logic [WS_W-1:0]                    window_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_side_reg <= swm2_pkg::MATRIX_SIDE_RST;
            window_side_reg <= swm2_pkg::WINDOW_SIDE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                swm2_pkg::REG_MATRIX_SIDE:
                    matrix_side_reg <= cfg_data[swm2_pkg::MATRIX_SIDE_W-1:0];
                swm2_pkg::REG_WINDOW_SIDE:
                    window_side_reg <= cfg_data[WS_W-1:0];
            endcase
        end
    end

    // effective sides: zero means one, matrix side saturates at the maximum
    logic [SIDE_W-1:0] n_eff;
    logic [WS_W-1:0]   w_eff;

    always_comb
    begin
        if (matrix_side_reg == '0)
        begin
            n_eff = SIDE_W'(1);
        end
        else if (32'(matrix_side_reg) > 32'(MAX_SIDE))
        begin
            n_eff = SIDE_W'(MAX_SIDE);
        end
        else
        begin
            n_eff = SIDE_W'(matrix_side_reg);
        end
    end

    assign w_eff = (window_side_reg == '0) ? WS_W'(1) : window_side_reg;

    // handshake
    logic s1_valid_reg;
    logic s1_we_reg;
    logic s1_prod_reg;
    logic result_valid_reg;
    logic out_load;
    logic s1_move;
    logic in_acc;

    assign out_load    = !result_valid_reg || !result_stall;
    // a stage-one item with no result may always move on
    assign s1_move     = !s1_valid_reg || !s1_prod_reg || out_load;
    assign pixel_stall = !s1_move;
    assign in_acc      = pixel_valid && s1_move;

    // position of the incoming item
    logic [POS_W-1:0] col_reg;
    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_cur;
    logic [POS_W-1:0] row_cur;
    logic [POS_W-1:0] col_next;
    logic [POS_W-1:0] row_next;
    logic [CW-1:0]    col_x;
    logic [CW-1:0]    row_x;
    logic [CW-1:0]    w_x;
    logic [CW-1:0]    n_x;
    logic             pos_in;
    logic             win_ok;
    logic             h_we;
    logic             prod;
    logic             is_last;
    logic             w_one;
    logic [POS_W-1:0] c0;
    logic [POS_W-1:0] r0;
    logic [POS_W-1:0] rd_addr;
    logic [TAP_W-1:0] tap_sel;

    always_comb
    begin
        n_x    = CW'(n_eff);
        w_x    = CW'(w_eff);
        // a position left beyond a shrunken side restarts at the origin
        pos_in = (CW'(col_reg) < n_x) && (CW'(row_reg) < n_x);
        if (pixel_item.frame_start || !pos_in)
        begin
            col_cur = '0;
            row_cur = '0;
        end
        else
        begin
            col_cur = col_reg;
            row_cur = row_reg;
        end
        col_x   = CW'(col_cur) + CW'(1);
        row_x   = CW'(row_cur) + CW'(1);
        win_ok  = (int'(w_eff) <= MAX_WINDOW) && (w_x <= n_x);
        h_we    = win_ok && (col_x >= w_x);
        prod    = h_we && (row_x >= w_x);
        c0      = POS_W'(col_x - w_x);
        r0      = POS_W'(row_x - w_x);
        is_last = (col_x == n_x) && (row_x == n_x);
        w_one   = (w_eff == WS_W'(1));
        rd_addr = h_we ? c0 : '0;
        tap_sel = ((w_eff >= WS_W'(2)) && win_ok) ? TAP_W'(w_eff - WS_W'(2)) : '0;

        // wrap to the next row, and past the last row to a new matrix
        if (col_x >= n_x)
        begin
            col_next = '0;
            row_next = (row_x >= n_x) ? '0 : POS_W'(row_x);
        end
        else
        begin
            col_next = POS_W'(col_x);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_acc)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // horizontal chain: cell k keeps the minimum of the newest k+1 pixels
    logic signed [swm2_pkg::DATA_W-1:0] h_min  [TAPS];
    logic signed [swm2_pkg::DATA_W-1:0] h_prev [TAPS];
    logic signed [swm2_pkg::DATA_W-1:0] row_min;

    for (genvar i = 0; i < TAPS; i++)
    begin : g_hcell
        if (i == 0)
        begin : g_first
            assign h_prev[i] = pixel_item.pixel_value;
        end
        else
        begin : g_rest
            assign h_prev[i] = h_min[i-1];
        end

        swm2_hcell u_hcell (
            .clk      (clk),
            .shift_en (in_acc),
            .pixel    (pixel_item.pixel_value),
            .prev_min (h_prev[i]),
            .run_min  (h_min[i])
        );
    end

    // row minimum of the horizontal window ending at this pixel
    assign row_min = w_one ? pixel_item.pixel_value :
                     swm2_pkg::smin(pixel_item.pixel_value, h_min[tap_sel]);

    // stage one: row minimum waits on the line buffer read
    logic signed [swm2_pkg::DATA_W-1:0] s1_m_reg;
    logic [POS_W-1:0]                   s1_c0_reg;
    logic [POS_W-1:0]                   s1_r0_reg;
    logic                               s1_last_reg;
    logic                               s1_one_reg;
    logic [TAP_W-1:0]                   s1_sel_reg;
    logic                               fwd_hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_we_reg    <= 1'b0;
            s1_prod_reg  <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= pixel_valid;
            s1_we_reg    <= h_we;
            s1_prod_reg  <= prod;
            // the leaving item writes the column the new item reads
            fwd_hit_reg  <= s1_valid_reg && s1_we_reg && (s1_c0_reg == rd_addr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s1_m_reg    <= row_min;
            s1_c0_reg   <= c0;
            s1_r0_reg   <= r0;
            s1_last_reg <= is_last;
            s1_one_reg  <= w_one;
            s1_sel_reg  <= tap_sel;
        end
    end

    // vertical chain: line j holds per column the minimum of j+1 row minima
    swm2_pkg::line_ctrl_t               line_ctrl;
    logic signed [swm2_pkg::DATA_W-1:0] v_old  [TAPS];
    logic signed [swm2_pkg::DATA_W-1:0] v_prev [TAPS];
    logic signed [swm2_pkg::DATA_W-1:0] win_min;

    always_comb
    begin
        line_ctrl.rd_en   = s1_move;
        line_ctrl.wr_en   = s1_move && s1_valid_reg && s1_we_reg;
        line_ctrl.fwd_hit = fwd_hit_reg;
    end

    for (genvar j = 0; j < TAPS; j++)
    begin : g_vcell
        if (j == 0)
        begin : g_first
            assign v_prev[j] = s1_m_reg;
        end
        else
        begin : g_rest
            assign v_prev[j] = v_old[j-1];
        end

        swm2_vcell #(
            .DEPTH (MAX_SIDE)
        ) u_vcell (
            .clk      (clk),
            .ctrl     (line_ctrl),
            .rd_addr  (rd_addr),
            .wr_addr  (s1_c0_reg),
            .row_min  (s1_m_reg),
            .prev_old (v_prev[j]),
            .old_val  (v_old[j])
        );
    end

    // window minimum: this row minimum against the previous rows of the column
    assign win_min = s1_one_reg ? s1_m_reg :
                     swm2_pkg::smin(s1_m_reg, v_old[s1_sel_reg]);

    // output register
    swm2_pkg::result_item_t result_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            result_valid_reg <= s1_valid_reg && s1_prod_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load && s1_valid_reg && s1_prod_reg)
        begin
            result_item_reg.window_min <= win_min;
            result_item_reg.out_row    <= OUT_W'(s1_r0_reg);
            result_item_reg.out_col    <= OUT_W'(s1_c0_reg);
            result_item_reg.last       <= s1_last_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result_item  = result_item_reg;

    // input stalls only behind a full, stalled output register and a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> (result_valid && result_stall && s1_valid_reg && s1_prod_reg))
        else $error("pixel stall without a blocked result");

    // a result only comes from a stage-one item that produces one
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(s1_valid_reg && s1_prod_reg))
        else $error("result appeared without a producing item");

    // every produced result also wrote its row minimum
    a_prod_writes: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_prod_reg && s1_move) |-> line_ctrl.wr_en)
        else $error("result item left stage one without a line write");

endmodule
